[hdl/dq_pkg.sv]
// Shared types and constants for the double-ended queue core.
package dq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int WORD_W        = 32;
    localparam int OCC_W         = 5;

    typedef enum logic [1:0] {
        MODE_PUSH_FRONT = 2'd0,
        MODE_PUSH_BACK  = 2'd1,
        MODE_POP_FRONT  = 2'd2,
        MODE_POP_BACK   = 2'd3
    } mode_t;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        mode_t                     mode;
        logic signed [WORD_W-1:0]  push_value;
    } dq_req_t;

    typedef struct packed {
        logic signed [WORD_W-1:0]  pop_value;
        logic [1:0]                status;
        logic [OCC_W-1:0]          occupancy;
    } dq_rsp_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic finish;
    } dq_cmd_t;

    typedef struct packed {
        logic out_free;
    } dq_stat_t;

endpackage

[hdl/dq_ctrl.sv]
// Controller state machine that sequences one request through the datapath.
module dq_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  dq_pkg::dq_stat_t stat,
    output dq_pkg::dq_cmd_t  cmd
);
    import dq_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[hdl/dq_datapath.sv]
// Datapath holding the entry memory, head index, entry count and result register.
module dq_datapath #(
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  dq_pkg::dq_req_t  in_data,
    input  dq_pkg::dq_cmd_t  cmd,
    output dq_pkg::dq_stat_t stat,
    output logic             out_valid,
    input  logic             out_ready,
    output dq_pkg::dq_rsp_t  out_data
);
    import dq_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    logic signed [WORD_W-1:0] mem [DEPTH];

    dq_req_t                  req_reg;
    logic [IDX_W-1:0]         head_reg;
    logic [IDX_W-1:0]         head_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic signed [WORD_W-1:0] rd_data_reg;
    logic                     pend_pop_reg;
    logic                     pend_pop_next;
    logic [1:0]               pend_status_reg;
    logic [1:0]               pend_status_next;
    logic [OCC_W-1:0]         pend_occ_reg;
    logic                     out_valid_reg;
    dq_rsp_t                  out_data_reg;
    dq_rsp_t                  out_data_next;

    logic                     is_full;
    logic                     is_empty;
    logic [IDX_W-1:0]         head_dec;
    logic [IDX_W-1:0]         head_inc;
    logic [SUM_W-1:0]         tail_sum;
    logic [SUM_W-1:0]         last_sum;
    logic [IDX_W-1:0]         tail_idx;
    logic [IDX_W-1:0]         last_idx;
    logic [IDX_W-1:0]         rd_addr;
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;

    assign is_full  = ({1'b0, count_reg} >= DEPTH_S);
    assign is_empty = (count_reg == '0);
    assign head_dec = (head_reg == '0) ? LAST_IDX : head_reg - 1'b1;
    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;

    assign tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign tail_idx = (tail_sum >= DEPTH_S) ? IDX_W'(tail_sum - DEPTH_S) : IDX_W'(tail_sum);
    assign last_sum = tail_sum - 1'b1;
    assign last_idx = (last_sum >= DEPTH_S) ? IDX_W'(last_sum - DEPTH_S) : IDX_W'(last_sum);

    always_comb
    begin
        head_next        = head_reg;
        count_next       = count_reg;
        pend_pop_next    = 1'b0;
        pend_status_next = STATUS_DONE;
        wr_en            = 1'b0;
        wr_addr          = tail_idx;
        rd_addr          = head_reg;
        case (req_reg.mode)
            MODE_PUSH_FRONT:
            begin
                wr_addr = head_dec;
                if (is_full)
                begin
                    pend_status_next = STATUS_FULL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    head_next  = head_dec;
                    count_next = count_reg + 1'b1;
                end
            end
            MODE_PUSH_BACK:
            begin
                if (is_full)
                begin
                    pend_status_next = STATUS_FULL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            MODE_POP_FRONT:
            begin
                if (is_empty)
                begin
                    pend_status_next = STATUS_EMPTY;
                end
                else
                begin
                    pend_pop_next = 1'b1;
                    head_next     = head_inc;
                    count_next    = count_reg - 1'b1;
                end
            end
            MODE_POP_BACK:
            begin
                rd_addr = last_idx;
                if (is_empty)
                begin
                    pend_status_next = STATUS_EMPTY;
                end
                else
                begin
                    pend_pop_next = 1'b1;
                    count_next    = count_reg - 1'b1;
                end
            end
            default:
            begin
                pend_status_next = STATUS_DONE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_en)
        begin
            mem[wr_addr] <= req_reg.push_value;
        end
        if (cmd.exec)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        out_data_next.status    = pend_status_reg;
        out_data_next.occupancy = pend_occ_reg;
        if (pend_pop_reg)
        begin
            out_data_next.pop_value = rd_data_reg;
        end
        else if (pend_status_reg == STATUS_EMPTY)
        begin
            out_data_next.pop_value = '1;
        end
        else
        begin
            out_data_next.pop_value = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= in_data;
        end
        if (cmd.exec)
        begin
            pend_pop_reg    <= pend_pop_next;
            pend_status_reg <= pend_status_next;
            pend_occ_reg    <= OCC_W'(count_next);
        end
        if (cmd.finish)
        begin
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                head_reg  <= head_next;
                count_reg <= count_next;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;

endmodule

[hdl/double_ended_queue_core.sv]
// Top level of the double-ended queue core: controller plus datapath.
//
// Requests arrive on the in channel (in_valid, in_ready, in_data) and carry a
// mode (push front, push back, pop front, pop back) and a word to push.
// Every request gives exactly one transfer on the out channel (out_valid,
// out_ready, out_data) with the popped word, a status and the occupancy.
// A pop on an empty queue returns -1 with the empty status; a push into a
// full queue is dropped and flagged with the full status.
// Each request moves through the core in order: the acceptance edge registers
// the request, the next edge does the memory access and pointer update, and a
// later edge loads the output register once it is free, making the result
// valid. The controller finishes one request before it takes the next, so no
// new request is accepted while one is still in the core.
// The next request may be accepted while an earlier result waits in the
// output register; if the receiver stalls, the core holds in its final step
// until the output register frees.
// Reset clears the head index and entry count, leaving the queue empty; the
// entry memory itself is not cleared.
module double_ended_queue_core #(
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  dq_pkg::dq_req_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output dq_pkg::dq_rsp_t out_data
);
    import dq_pkg::*;

    dq_cmd_t  cmd;
    dq_stat_t stat;

    dq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
